// ===== rtl/ovl_pkg.sv =====
// Shared types and constants for the ordered value list engine.
`default_nettype none

package ovl_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 32;
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_DELETE     = 2'd2,
      CMD_SEARCH     = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE    = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_MISSING = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch command, compare all cells
      logic commit;    // apply update, load result register
   } ctl_type;

endpackage

`default_nettype wire

// ===== rtl/ovl_if.sv =====
// Valid/ready channel interfaces for commands and responses.
`default_nettype none

interface ovl_req_if import ovl_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface ovl_rsp_if import ovl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic                 found;
   logic [COUNT_W-1:0]   entry_count;

   modport source (output valid, output status, output found, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input found, input entry_count,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/ovl_ctrl.sv =====
// Controller FSM: sequences compare and commit, owns the response valid flag.
`default_nettype none

module ovl_ctrl import ovl_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output ctl_type      ctl
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      ctl.capture = 1'b0;
      ctl.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            ctl.capture = req_valid;
         end
         ST_EXEC: begin
            ctl.commit = slot_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (ctl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ovl_datapath.sv =====
// Datapath: chain of value cells, parallel compare, shift update, result register.
`default_nettype none

module ovl_datapath import ovl_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ctl_type                   ctl,
   input  wire logic [CMD_W-1:0]          req_command,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic                           rsp_found,
   output logic [COUNT_W-1:0]             rsp_entry_count
);

   localparam int LEN_W  = $clog2(CAPACITY + 1);
   localparam int STAGES = $clog2(CAPACITY);

   logic [VALUE_W-1:0]  cells_ff [CAPACITY];
   logic [VALUE_W-1:0]  cells_in [CAPACITY];
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [CAPACITY-1:0] match_ff, match_in;
   logic [CMD_W-1:0]    cmd_ff;
   logic [VALUE_W-1:0]  value_ff;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic                found_ff, found_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   logic                full;
   logic                any_match;
   logic [CAPACITY-1:0] prefix [STAGES+1];
   logic [LEN_W+COUNT_W-1:0] len_ext;

   // each cell compares itself against the incoming value
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
      assign match_in[i] = (cells_ff[i] == req_value) && (LEN_W'(i) < len_ff);
   end

   // prefix OR: cells at or behind the first match shift toward the front
   assign prefix[0] = match_ff;
   for (genvar s = 0; s < STAGES; s++) begin : g_pre
      for (genvar i = 0; i < CAPACITY; i++) begin : g_bit
         if (i >= (1 << s)) begin : g_or
            assign prefix[s+1][i] = prefix[s][i] | prefix[s][i - (1 << s)];
         end else begin : g_pass
            assign prefix[s+1][i] = prefix[s][i];
         end
      end
   end

   assign full      = (len_ff == LEN_W'(CAPACITY));
   assign any_match = |match_ff;

   always_comb begin
      cells_in  = cells_ff;
      len_in    = len_ff;
      status_in = status_ff;
      found_in  = found_ff;
      if (ctl.commit) begin
         status_in = STAT_DONE;
         found_in  = 1'b0;
         case (cmd_type'(cmd_ff))
            CMD_PUSH_FRONT: begin
               if (full) begin
                  status_in = STAT_FULL;
               end else begin
                  cells_in[0] = value_ff;
                  for (int i = 1; i < CAPACITY; i++) begin
                     cells_in[i] = cells_ff[i-1];
                  end
                  len_in = len_ff + LEN_W'(1);
               end
            end
            CMD_PUSH_BACK: begin
               if (full) begin
                  status_in = STAT_FULL;
               end else begin
                  for (int i = 0; i < CAPACITY; i++) begin
                     if (LEN_W'(i) == len_ff) cells_in[i] = value_ff;
                  end
                  len_in = len_ff + LEN_W'(1);
               end
            end
            CMD_DELETE: begin
               if (!any_match) begin
                  status_in = STAT_MISSING;
               end else begin
                  for (int i = 0; i < CAPACITY - 1; i++) begin
                     if (prefix[STAGES][i]) cells_in[i] = cells_ff[i+1];
                  end
                  len_in   = len_ff - LEN_W'(1);
                  found_in = 1'b1;
               end
            end
            CMD_SEARCH: begin
               if (!any_match) begin
                  status_in = STAT_MISSING;
               end else begin
                  found_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign len_ext  = {{COUNT_W{1'b0}}, len_in};
   assign count_in = ctl.commit ? len_ext[COUNT_W-1:0] : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      cells_ff  <= cells_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      count_ff  <= count_in;
      if (ctl.capture) begin
         match_ff <= match_in;
         cmd_ff   <= req_command;
         value_ff <= req_value;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_entry_count = count_ff;

endmodule

`default_nettype wire

// ===== rtl/ordered_value_list_engine.sv =====
// Top level of the ordered value list engine: controller plus cell datapath.
//
//  channel   | dir | signals                               | handshake
//  ----------+-----+---------------------------------------+-----------
//  req_chan  | in  | command[1:0], value[31:0] signed       | valid/ready
//  rsp_chan  | out | status[1:0], found, entry_count[4:0]   | valid/ready
//
//  One command is in flight at a time. Its accept edge compares every cell
//  against the value at once; its commit edge, taken when the response slot
//  is free, applies the shift/append and loads the response register.
//  Reset clears the entry count, the FSM and response valid; cell contents are
//  left as they are (never read before written).
//  A held response stalls the commit, not the accept: a new command is taken
//  while the previous response waits, and commits once that response leaves.
`default_nettype none

module ordered_value_list_engine import ovl_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ovl_req_if.sink    req_chan,
   ovl_rsp_if.source  rsp_chan
);

   ctl_type ctl;

   // sequencing: idle -> exec, commit waits on a free response slot
   ovl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .ctl       (ctl)
   );

   // cells, count, match vector and response register
   ovl_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .req_command     (req_chan.command),
      .req_value       (req_chan.value),
      .rsp_status      (rsp_chan.status),
      .rsp_found       (rsp_chan.found),
      .rsp_entry_count (rsp_chan.entry_count)
   );

endmodule

`default_nettype wire
